>>> rtl/lbpc_pkg.sv
// Shared types, codes and constants of the light barrier people counter.
`default_nettype none
package lbpc_pkg;

  localparam int TIME_W  = 32;
  localparam int HIST_N  = 4;
  localparam int SPAN_W  = 16;
  localparam int COUNT_W = 7;
  localparam int IDX_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic [SPAN_W-1:0]  MIN_SPAN_RST  = SPAN_W'(150);
  localparam logic [SPAN_W-1:0]  MAX_SPAN_RST  = SPAN_W'(1500);
  localparam logic [SPAN_W-1:0]  SETTLE_RST    = SPAN_W'(500);
  localparam logic [COUNT_W-1:0] MAX_COUNT_RST = COUNT_W'(99);

  // bit i holds history entry i, entry 3 is the newest
  localparam logic [HIST_N-1:0] PAT_ENTER_S [2] = '{4'b0101, 4'b0011};
  localparam logic [HIST_N-1:0] PAT_ENTER_L [2] = '{4'b0011, 4'b0101};
  localparam logic [HIST_N-1:0] PAT_EXIT_S  [2] = '{4'b1010, 4'b1100};
  localparam logic [HIST_N-1:0] PAT_EXIT_L  [2] = '{4'b0011, 4'b0101};

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_SPAN  = 2'd0,
    REG_MAX_SPAN  = 2'd1,
    REG_SETTLE    = 2'd2,
    REG_MAX_COUNT = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_NO_PATTERN = 3'd1,
    ST_MANIP      = 3'd2,
    ST_TOO_SLOW   = 3'd3,
    ST_ENTER      = 3'd4,
    ST_EXIT       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    DEC_NONE  = 2'd0,
    DEC_ENTRY = 2'd1,
    DEC_EXIT  = 2'd2,
    DEC_TURN  = 2'd3
  } decision_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_ENTER = 2'd1,
    PEND_EXIT  = 2'd2
  } pend_t;

  typedef struct packed {
    logic [SPAN_W-1:0]  min_span_ms;
    logic [SPAN_W-1:0]  max_span_ms;
    logic [SPAN_W-1:0]  settle_ms;
    logic [COUNT_W-1:0] max_count;
  } cfg_t;

  typedef struct packed {
    op_t               opcode;
    logic              sensor;
    logic              level;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] people_now;
    status_t            detect_status;
    decision_t          decision;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/light_barrier_people_counter.sv
// Top level of the light barrier direction detector and people counter.
//
//  channel | direction | beat contents
//  in_     | slave     | tuser: opcode; tdata: sensor, level, time_ms
//  out_    | master    | tdata: people_now, detect_status, decision
//  cfg_    | slave     | cfg_index register number, cfg_data value
//
// One beat per cycle sustained while the result is taken; a beat passes the input
// register, then the single-pass detect logic, into the result register.
// Reset clears the history valid bits, the count, the pending decision and
// loads the register defaults. A stalled result stalls the detect logic and
// the input register holds one more beat. Configuration is always ready.
`default_nettype none
module light_barrier_people_counter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lbpc_pkg::IN_TDATA_W-1:0]    in_tdata,  // sensor, level, time_ms[31:0]
  input  wire logic                               in_tuser,  // opcode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [lbpc_pkg::OUT_TDATA_W-1:0]        out_tdata, // people_now, detect_status, decision
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lbpc_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [lbpc_pkg::SPAN_W-1:0]        cfg_data
);

  lbpc_pkg::cfg_t      cfg_r;
  lbpc_pkg::in_item_t  in_item, hold_item;
  lbpc_pkg::out_item_t res, out_item;
  logic                hold_valid, free, fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_span_ms <= lbpc_pkg::MIN_SPAN_RST;
      cfg_r.max_span_ms <= lbpc_pkg::MAX_SPAN_RST;
      cfg_r.settle_ms   <= lbpc_pkg::SETTLE_RST;
      cfg_r.max_count   <= lbpc_pkg::MAX_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lbpc_pkg::reg_idx_t'(cfg_index))
        lbpc_pkg::REG_MIN_SPAN:  cfg_r.min_span_ms <= cfg_data;
        lbpc_pkg::REG_MAX_SPAN:  cfg_r.max_span_ms <= cfg_data;
        lbpc_pkg::REG_SETTLE:    cfg_r.settle_ms   <= cfg_data;
        lbpc_pkg::REG_MAX_COUNT: cfg_r.max_count   <= cfg_data[lbpc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.opcode  = lbpc_pkg::op_t'(in_tuser);
  assign in_item.sensor  = in_tdata[0];
  assign in_item.level   = in_tdata[1];
  assign in_item.time_ms = in_tdata[lbpc_pkg::TIME_W+1:2];

  assign fire = hold_valid && free;

  lbpc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .take       (fire),
    .hold_item  (hold_item)
  );

  lbpc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .item  (hold_item),
    .res   (res)
  );

  lbpc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .free      (free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {4'b0000, out_item.decision, out_item.detect_status, out_item.people_now};

endmodule
`default_nettype wire

>>> rtl/lbpc_in_stage.sv
// Input register stage of the light barrier people counter.
`default_nettype none
module lbpc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lbpc_pkg::in_item_t in_item,
  output logic                   hold_valid,
  input  wire logic              take,
  output lbpc_pkg::in_item_t     hold_item
);

  logic               valid_r;
  logic               valid_nxt;
  lbpc_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lbpc_core.sv
// History, pattern detection, pending decision and people count.
`default_nettype none
module lbpc_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lbpc_pkg::cfg_t      cfg,
  input  wire logic                fire,
  input  wire lbpc_pkg::in_item_t  item,
  output lbpc_pkg::out_item_t      res
);

  localparam int TW = lbpc_pkg::TIME_W;
  localparam int HN = lbpc_pkg::HIST_N;
  localparam int CW = lbpc_pkg::COUNT_W;

  logic [HN-1:0]      hs_r, hl_r, hv_r;
  logic [TW-1:0]      ht_r [HN];
  logic [CW-1:0]      people_r, people_nxt;
  lbpc_pkg::pend_t    pend_r, pend_nxt;
  logic [TW-1:0]      deadline_r, deadline_nxt;

  logic [HN-1:0]      hs_sh, hl_sh, hv_sh, hv_nxt;
  logic [TW-1:0]      ht_sh [HN];
  logic               is_event, due, full, armed, do_res, want, turned;
  logic               match_enter, match_exit;
  logic [TW-1:0]      now, delta, span;
  logic [1:0]         rs, rl, rv;
  lbpc_pkg::status_t  status;
  lbpc_pkg::decision_t dec;

  assign now      = item.time_ms;
  assign is_event = (item.opcode == lbpc_pkg::OP_EVENT);
  assign delta    = now - deadline_r;
  assign due      = (pend_r != lbpc_pkg::PEND_NONE) && !delta[TW-1];

  always_comb begin
    hs_sh = hs_r;
    hl_sh = hl_r;
    hv_sh = hv_r;
    for (int i = 0; i < HN; i++) begin
      ht_sh[i] = ht_r[i];
    end
    if (is_event) begin
      hs_sh = {item.sensor, hs_r[HN-1:1]};
      hl_sh = {item.level, hl_r[HN-1:1]};
      hv_sh = {1'b1, hv_r[HN-1:1]};
      for (int i = 0; i < HN - 1; i++) begin
        ht_sh[i] = ht_r[i+1];
      end
      ht_sh[HN-1] = now;
    end
  end

  assign full = &hv_sh;
  assign span = now - ht_sh[0];

  assign match_enter = ((hs_sh == lbpc_pkg::PAT_ENTER_S[0]) && (hl_sh == lbpc_pkg::PAT_ENTER_L[0]))
                    || ((hs_sh == lbpc_pkg::PAT_ENTER_S[1]) && (hl_sh == lbpc_pkg::PAT_ENTER_L[1]));
  assign match_exit  = ((hs_sh == lbpc_pkg::PAT_EXIT_S[0]) && (hl_sh == lbpc_pkg::PAT_EXIT_L[0]))
                    || ((hs_sh == lbpc_pkg::PAT_EXIT_S[1]) && (hl_sh == lbpc_pkg::PAT_EXIT_L[1]));

  always_comb begin
    if (!is_event) begin
      status = lbpc_pkg::ST_NONE;
    end else if (!full) begin
      status = lbpc_pkg::ST_NO_PATTERN;
    end else if (span < {{(TW-lbpc_pkg::SPAN_W){1'b0}}, cfg.min_span_ms}) begin
      status = lbpc_pkg::ST_MANIP;
    end else if (span > {{(TW-lbpc_pkg::SPAN_W){1'b0}}, cfg.max_span_ms}) begin
      status = lbpc_pkg::ST_TOO_SLOW;
    end else if (match_enter) begin
      status = lbpc_pkg::ST_ENTER;
    end else if (match_exit) begin
      status = lbpc_pkg::ST_EXIT;
    end else begin
      status = lbpc_pkg::ST_NO_PATTERN;
    end
  end

  assign armed  = (status == lbpc_pkg::ST_ENTER) || (status == lbpc_pkg::ST_EXIT);
  assign do_res = due || (armed && (pend_r != lbpc_pkg::PEND_NONE));

  // a due decision sees the history before this beat, a displaced one sees it after
  assign rs     = due ? hs_r[HN-1:HN-2] : hs_sh[HN-1:HN-2];
  assign rl     = due ? hl_r[HN-1:HN-2] : hl_sh[HN-1:HN-2];
  assign rv     = due ? hv_r[HN-1:HN-2] : hv_sh[HN-1:HN-2];
  assign want   = (pend_r == lbpc_pkg::PEND_ENTER);
  assign turned = rv[1] && rv[0] && (rs[1] == want) && (rs[0] == want) && rl[0] && !rl[1];

  always_comb begin
    people_nxt = people_r;
    dec        = lbpc_pkg::DEC_NONE;
    if (do_res) begin
      if (turned) begin
        dec = lbpc_pkg::DEC_TURN;
      end else if (pend_r == lbpc_pkg::PEND_ENTER) begin
        dec = lbpc_pkg::DEC_ENTRY;
        if (people_r < cfg.max_count) begin
          people_nxt = people_r + CW'(1);
        end
      end else begin
        dec = lbpc_pkg::DEC_EXIT;
        if (people_r != '0) begin
          people_nxt = people_r - CW'(1);
        end
      end
    end
  end

  always_comb begin
    pend_nxt     = pend_r;
    deadline_nxt = deadline_r;
    hv_nxt       = hv_sh;
    if (do_res) begin
      pend_nxt = lbpc_pkg::PEND_NONE;
    end
    if (armed) begin
      pend_nxt     = (status == lbpc_pkg::ST_ENTER) ? lbpc_pkg::PEND_ENTER : lbpc_pkg::PEND_EXIT;
      deadline_nxt = now + {{(TW-lbpc_pkg::SPAN_W){1'b0}}, cfg.settle_ms};
      hv_nxt       = '0;
    end
  end

  assign res.people_now    = people_nxt;
  assign res.detect_status = status;
  assign res.decision      = dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r     <= '0;
      people_r <= '0;
      pend_r   <= lbpc_pkg::PEND_NONE;
    end else if (fire) begin
      hv_r     <= hv_nxt;
      people_r <= people_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hs_r       <= hs_sh;
      hl_r       <= hl_sh;
      deadline_r <= deadline_nxt;
      for (int i = 0; i < HN; i++) begin
        ht_r[i] <= ht_sh[i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_dec_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (dec != lbpc_pkg::DEC_NONE) |-> (pend_r != lbpc_pkg::PEND_NONE))
    else $error("decision reported with nothing pending");

  a_match_arms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && armed |=> (pend_r != lbpc_pkg::PEND_NONE) && (hv_r == '0))
    else $error("match did not arm a decision and clear the history");

  a_count_moves_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(people_r) |-> $past(fire) && $past(do_res))
    else $error("count changed without a resolved decision");

  a_tick_keeps_history: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !is_event |=> $stable(hv_r))
    else $error("tick altered the history");
`endif

endmodule
`default_nettype wire

>>> rtl/lbpc_out_stage.sv
// Result register stage of the light barrier people counter.
`default_nettype none
module lbpc_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire lbpc_pkg::out_item_t res,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lbpc_pkg::out_item_t      out_item
);

  logic                valid_r;
  logic                valid_nxt;
  lbpc_pkg::out_item_t item_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking stream testbench of the light barrier people counter with a built-in predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbpc_pkg::*;

  typedef struct packed {
    op_t                op;
    logic               sensor;
    logic               level;
    logic [TIME_W-1:0]  stamp;
    logic               typed;
    logic [COUNT_W-1:0] people;
    status_t            status;
    decision_t          decision;
  } dir_row_t;

  localparam int DIR_N = 26;

  // walk orders of the two barriers: two entering, then two leaving; bit i is entry i
  localparam logic [HIST_N-1:0] WALK_S [4] = '{4'b0101, 4'b0011, 4'b1010, 4'b1100};
  localparam logic [HIST_N-1:0] WALK_L [4] = '{4'b0011, 4'b0101, 4'b0011, 4'b0101};

  dir_row_t directed_rows [DIR_N] = '{
    '{OP_TICK,  1'b0, 1'b0, 32'd0,          1'b1, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b1, 32'd0,          1'b1, 7'd0, ST_NO_PATTERN, DEC_NONE},
    '{OP_EVENT, 1'b1, 1'b1, 32'd1000,       1'b1, 7'd0, ST_NO_PATTERN, DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b1, 32'd1100,       1'b1, 7'd0, ST_NO_PATTERN, DEC_NONE},
    '{OP_EVENT, 1'b1, 1'b0, 32'd1200,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b0, 32'd1300,       1'b1, 7'd0, ST_ENTER,      DEC_NONE},
    '{OP_TICK,  1'b1, 1'b1, 32'd1799,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_TICK,  1'b0, 1'b0, 32'd1800,       1'b1, 7'd1, ST_NONE,       DEC_ENTRY},
    '{OP_EVENT, 1'b0, 1'b1, 32'd2000,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b0, 32'd2100,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b1, 1'b1, 32'd2200,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b1, 1'b0, 32'd2300,       1'b1, 7'd1, ST_EXIT,       DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b1, 32'd2400,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b0, 32'd2500,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_TICK,  1'b0, 1'b0, 32'd2800,       1'b1, 7'd1, ST_NONE,       DEC_TURN},
    '{OP_EVENT, 1'b1, 1'b1, 32'd3000,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b1, 32'd3010,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b1, 1'b0, 32'd3020,       1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b0, 32'd3030,       1'b1, 7'd1, ST_MANIP,      DEC_NONE},
    '{OP_EVENT, 1'b1, 1'b1, 32'd9000,       1'b1, 7'd1, ST_TOO_SLOW,   DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b1, 32'hFFFF_FF00,  1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b1, 1'b1, 32'hFFFF_FF80,  1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b0, 1'b0, 32'h0000_0010,  1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_EVENT, 1'b1, 1'b0, 32'h0000_0090,  1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_TICK,  1'b1, 1'b0, 32'hFFFF_FFFF,  1'b0, 7'd0, ST_NONE,       DEC_NONE},
    '{OP_TICK,  1'b0, 1'b1, 32'h0000_0284,  1'b1, 7'd0, ST_NONE,       DEC_EXIT}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // sensor, level, time_ms[31:0], pad
  logic                   in_tuser = 1'b0; // opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // people_now, detect_status, decision, pad
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [SPAN_W-1:0]      cfg_data = '0;

  light_barrier_people_counter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state
  logic [HIST_N-1:0]  hist_s = '0;
  logic [HIST_N-1:0]  hist_l = '0;
  logic [HIST_N-1:0]  hist_v = '0;
  logic [TIME_W-1:0]  hist_t [HIST_N] = '{default: '0};
  logic [COUNT_W-1:0] people_model = '0;
  pend_t              armed = PEND_NONE;
  logic [TIME_W-1:0]  due_ms = '0;
  logic [SPAN_W-1:0]  min_span = MIN_SPAN_RST;
  logic [SPAN_W-1:0]  max_span = MAX_SPAN_RST;
  logic [SPAN_W-1:0]  settle = SETTLE_RST;
  logic [COUNT_W-1:0] count_cap = MAX_COUNT_RST;

  out_item_t   expected_reports [$];
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned reports_seen = 0;
  int unsigned settings_used = 1;
  int unsigned status_seen [8] = '{default: 0};
  int unsigned decision_seen [4] = '{default: 0};
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  logic [TIME_W-1:0] now_ms = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("light_barrier_people_counter: mismatch");
    $finish;
  end

  function automatic decision_t settle_decision();
    logic      want;
    logic      turned;
    decision_t d;
    want = (armed == PEND_ENTER);
    turned = hist_v[2] && hist_v[3] && hist_s[2] == want && hist_s[3] == want &&
             hist_l[2] && !hist_l[3];
    d = DEC_NONE;
    if (turned) begin
      d = DEC_TURN;
    end else if (armed == PEND_ENTER) begin
      if (people_model < count_cap) people_model++;
      d = DEC_ENTRY;
    end else if (armed == PEND_EXIT) begin
      if (people_model != 0) people_model--;
      d = DEC_EXIT;
    end
    armed = PEND_NONE;
    return d;
  endfunction

  function automatic out_item_t barrier_step(input op_t op, input logic sensor,
                                             input logic level, input logic [TIME_W-1:0] stamp);
    out_item_t         r;
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] span;
    pend_t             kind;
    int                i;
    r.detect_status = ST_NONE;
    r.decision = DEC_NONE;
    since = stamp - due_ms;
    if (armed != PEND_NONE && !since[TIME_W-1]) r.decision = settle_decision();
    if (op == OP_EVENT) begin
      hist_s = {sensor, hist_s[HIST_N-1:1]};
      hist_l = {level, hist_l[HIST_N-1:1]};
      hist_v = {1'b1, hist_v[HIST_N-1:1]};
      for (i = 0; i < HIST_N - 1; i++) hist_t[i] = hist_t[i+1];
      hist_t[HIST_N-1] = stamp;
      span = hist_t[HIST_N-1] - hist_t[0];
      kind = PEND_NONE;
      for (i = 0; i < 4; i++) begin
        if (kind == PEND_NONE && hist_s == WALK_S[i] && hist_l == WALK_L[i]) begin
          kind = (i < 2) ? PEND_ENTER : PEND_EXIT;
        end
      end
      if (hist_v != '1) begin
        r.detect_status = ST_NO_PATTERN;
      end else if (span < TIME_W'(min_span)) begin
        r.detect_status = ST_MANIP;
      end else if (span > TIME_W'(max_span)) begin
        r.detect_status = ST_TOO_SLOW;
      end else if (kind == PEND_NONE) begin
        r.detect_status = ST_NO_PATTERN;
      end else begin
        r.detect_status = (kind == PEND_ENTER) ? ST_ENTER : ST_EXIT;
        if (armed != PEND_NONE) r.decision = settle_decision();
        hist_s = '0;
        hist_l = '0;
        hist_v = '0;
        armed = kind;
        due_ms = stamp + TIME_W'(settle);
      end
    end
    r.people_now = people_model;
    return r;
  endfunction

  task automatic send_beat(input op_t op, input logic sensor, input logic level,
                           input logic [TIME_W-1:0] stamp, input logic typed,
                           input out_item_t typed_exp);
    out_item_t predicted;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, stamp, level, sensor};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = barrier_step(op, sensor, level, stamp);
    expected_reports.push_back(typed ? typed_exp : predicted);
    beats_in++;
  endtask

  task automatic wait_idle();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [SPAN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_SPAN:  min_span = value;
      REG_MAX_SPAN:  max_span = value;
      REG_SETTLE:    settle = value;
      REG_MAX_COUNT: count_cap = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [SPAN_W-1:0] lo, input logic [SPAN_W-1:0] hi,
                           input logic [SPAN_W-1:0] wait_ms, input logic [SPAN_W-1:0] cap_raw,
                           input int unsigned gap, input int unsigned stall,
                           input int unsigned pace, input int unsigned n_items,
                           input bit hold_mid);
    int unsigned sent;
    int unsigned pick;
    int unsigned p;
    int unsigned k;
    bit          held;
    logic        want;
    write_reg(REG_MIN_SPAN, lo);
    write_reg(REG_MAX_SPAN, hi);
    write_reg(REG_SETTLE, wait_ms);
    write_reg(REG_MAX_COUNT, cap_raw);
    cfg_valid <= 1'b0;
    settings_used++;
    send_gap_pct = gap;
    stall_pct = stall;
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      if (hold_mid && !held && sent >= n_items / 2) begin
        in_tvalid <= 1'b0;
        wait_idle();
        held = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        p = $urandom_range(3);
        for (k = 0; k < 4; k++) begin
          now_ms += $urandom_range(pace);
          send_beat(OP_EVENT, WALK_S[p][k], WALK_L[p][k], now_ms, 1'b0, '0);
        end
        sent += 4;
        if ($urandom_range(2) == 0) begin
          want = (p < 2);
          if ($urandom_range(3) == 0) want = 1'($urandom_range(1));
          now_ms += $urandom_range(pace);
          send_beat(OP_EVENT, want, 1'b1, now_ms, 1'b0, '0);
          now_ms += $urandom_range(pace);
          send_beat(OP_EVENT, want, 1'b0, now_ms, 1'b0, '0);
          sent += 2;
        end
      end else if (pick < 80) begin
        now_ms += $urandom_range(2 * pace);
        send_beat(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), now_ms,
                  1'b0, '0);
        sent++;
      end else if (pick < 95) begin
        now_ms += $urandom_range(pace);
        send_beat(OP_EVENT, 1'($urandom_range(1)), 1'($urandom_range(1)), now_ms,
                  1'b0, '0);
        sent++;
      end else begin
        now_ms = $urandom();
        send_beat(op_t'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  now_ms, 1'b0, '0);
        sent++;
      end
    end
    in_tvalid <= 1'b0;
    wait_idle();
  endtask

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.people_now    = out_tdata[6:0];
      got.detect_status = status_t'(out_tdata[9:7]);
      got.decision      = decision_t'(out_tdata[11:10]);
      reports_seen++;
      status_seen[out_tdata[9:7]]++;
      decision_seen[out_tdata[11:10]]++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected beat people %0d status %0d decision %0d", $time,
                 got.people_now, got.detect_status, got.decision);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          $display("%0t: expected people %0d status %0d decision %0d, got %0d %0d %0d",
                   $time, want.people_now, want.detect_status, want.decision,
                   got.people_now, got.detect_status, got.decision);
          mismatches++;
        end
      end
    end
  end

  initial begin
    out_item_t typed_exp;
    int        r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (r = 0; r < DIR_N; r++) begin
      typed_exp.people_now    = directed_rows[r].people;
      typed_exp.detect_status = directed_rows[r].status;
      typed_exp.decision      = directed_rows[r].decision;
      send_beat(directed_rows[r].op, directed_rows[r].sensor, directed_rows[r].level,
                directed_rows[r].stamp, directed_rows[r].typed, typed_exp);
    end
    in_tvalid <= 1'b0;
    wait_idle();
    now_ms = 32'h0000_1000;
    run_phase(16'd150,   16'd1500,  16'd500,   16'd99,    0,  0,  400, 190, 1'b0);
    run_phase(16'd0,     16'd65535, 16'd0,     16'hFF7F,  46, 0,  3000, 190, 1'b0);
    run_phase(16'd65535, 16'd65535, 16'd65535, 16'h0000,  0,  46, 200, 190, 1'b0);
    run_phase(16'd0,     16'd0,     16'd100,   16'h0003,  10, 10, 1,   190, 1'b0);
    run_phase(16'd200,   16'd2000,  16'd1000,  16'h8001,  0,  46, 600, 190, 1'b0);
    run_phase(16'd150,   16'd1500,  16'd500,   16'hAB63,  10, 10, 500, 190, 1'b1);
    $display("%0d beats in under %0d register settings, %0d results checked", beats_in,
             settings_used, reports_seen);
    $display("status none/none-match/manip/slow/enter/exit %0d/%0d/%0d/%0d/%0d/%0d, %s %0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5], "entries/exits/turnarounds", decision_seen[1], decision_seen[2],
             decision_seen[3]);
    if (mismatches == 0) begin
      $display("light_barrier_people_counter: match");
    end else begin
      $display("light_barrier_people_counter: mismatch");
    end
    $finish;
  end

endmodule

>>> light_barrier_people_counter.f
rtl/lbpc_pkg.sv
rtl/lbpc_in_stage.sv
rtl/lbpc_core.sv
rtl/lbpc_out_stage.sv
rtl/light_barrier_people_counter.sv
test/testbench.sv
